// ----- rtl/core/cdm_pkg.sv -----
// ----------------------------------------------------------------------------
// cdm_pkg: shared types and constants of the color distance mask unit
// Widths, register codes, falloff limits and the words that travel down the
// square root and divider cell chains.
// ----------------------------------------------------------------------------
package cdm_pkg;

  // Channel and register widths
  localparam int CH_W      = 16;
  localparam int FALLOFF_W = 15;
  localparam int ADDR_W    = 4;
  localparam int DATA_W    = 32;

  // Register codes, taken from paddr[3:2]
  typedef logic [1:0] reg_idx_t;
  localparam reg_idx_t REG_TARGET_RED   = 2'd0;
  localparam reg_idx_t REG_TARGET_GREEN = 2'd1;
  localparam reg_idx_t REG_TARGET_BLUE  = 2'd2;
  localparam reg_idx_t REG_FALLOFF      = 2'd3;

  // Reset values
  localparam logic [CH_W-1:0]      TARGET_RESET  = 16'd65535;
  localparam logic [FALLOFF_W-1:0] FALLOFF_RESET = 15'd2458;

  // Falloff limits, Q1.14 (0.001 .. 1.732)
  localparam logic [FALLOFF_W-1:0] FALLOFF_MIN = 15'd17;
  localparam logic [FALLOFF_W-1:0] FALLOFF_MAX = 15'd28377;

  // Divisor is 65535 * falloff
  localparam int DIVISOR_W = 31;
  localparam logic [DIVISOR_W-1:0] DIVISOR_MIN = 31'd1114095;
  localparam logic [DIVISOR_W-1:0] DIVISOR_MAX = 31'd1859686695;

  // Sum of squared differences and square root chain
  localparam int SQ_W      = 32;
  localparam int SUM_W     = 34;
  localparam int SQ_IN_W   = 50;
  localparam int SQ_ROOT_W = 25;
  localparam int SQ_REM_W  = 27;

  // Divider chain: 17 quotient bits, 32 bit partial remainder
  localparam int DIV_REM_W = 32;
  localparam int DIV_Q_W   = 17;

  // Smoothstep constants, Q16
  localparam logic [DIV_Q_W-1:0] ONE_Q16   = 17'd65536;
  localparam logic [17:0]        THREE_Q16 = 18'd196608;
  localparam int PROD_W = 51;
  localparam logic [PROD_W-1:0]  ROUND_HALF = 51'd2147483648;

  // Configuration as seen by the datapath
  typedef struct packed {
    logic [CH_W-1:0]      target_red;
    logic [CH_W-1:0]      target_green;
    logic [CH_W-1:0]      target_blue;
    logic [DIVISOR_W-1:0] divisor;
  } cfg_t;

  // Word handed from one square root cell to the next
  typedef struct packed {
    logic [SQ_IN_W-1:0]   x;
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } sqrt_word_t;

  // Word handed from one divider cell to the next
  typedef struct packed {
    logic                 sat;
    logic [DIV_REM_W-1:0] rem;
    logic [DIV_Q_W-1:0]   quo;
  } div_word_t;

endpackage

// ----- rtl/core/cdm_ifs.sv -----
// ----------------------------------------------------------------------------
// cdm_ifs: stream interfaces of the color distance mask unit
// Pixel channel in, mask channel out, both valid/ready.
// ----------------------------------------------------------------------------
interface cdm_pixel_if;
  logic                     valid;
  logic                     ready;
  logic [cdm_pkg::CH_W-1:0] pixel_red;
  logic [cdm_pkg::CH_W-1:0] pixel_green;
  logic [cdm_pkg::CH_W-1:0] pixel_blue;

  modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                  input ready);
  modport sink (input valid, input pixel_red, input pixel_green, input pixel_blue,
                output ready);
endinterface

interface cdm_mask_if;
  logic                     valid;
  logic                     ready;
  logic [cdm_pkg::CH_W-1:0] mask_value;

  modport source (output valid, output mask_value, input ready);
  modport sink (input valid, input mask_value, output ready);
endinterface

// ----- rtl/core/cdm_apb_regs.sv -----
// ----------------------------------------------------------------------------
// cdm_apb_regs: configuration registers
// Target color and falloff radius, APB write and read, clamped divisor.
// ----------------------------------------------------------------------------
module cdm_apb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cdm_pkg::ADDR_W-1:0]   paddr,
  input  logic [cdm_pkg::DATA_W-1:0]   pwdata,
  output logic [cdm_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  output cdm_pkg::cfg_t                cfg
);

  logic [cdm_pkg::CH_W-1:0]      target_red;
  logic [cdm_pkg::CH_W-1:0]      target_green;
  logic [cdm_pkg::CH_W-1:0]      target_blue;
  logic [cdm_pkg::FALLOFF_W-1:0] falloff;
  logic [cdm_pkg::FALLOFF_W-1:0] falloff_clamped;
  logic [cdm_pkg::DIVISOR_W-1:0] divisor;
  logic [cdm_pkg::DIVISOR_W-1:0] divisor_next;
  logic                          wr_en;
  cdm_pkg::reg_idx_t             idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[3:2];

  // Write registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_red   <= cdm_pkg::TARGET_RESET;
      target_green <= cdm_pkg::TARGET_RESET;
      target_blue  <= cdm_pkg::TARGET_RESET;
      falloff      <= cdm_pkg::FALLOFF_RESET;
    end else if (wr_en) begin
      unique case (idx)
        cdm_pkg::REG_TARGET_RED:   target_red   <= pwdata[cdm_pkg::CH_W-1:0];
        cdm_pkg::REG_TARGET_GREEN: target_green <= pwdata[cdm_pkg::CH_W-1:0];
        cdm_pkg::REG_TARGET_BLUE:  target_blue  <= pwdata[cdm_pkg::CH_W-1:0];
        cdm_pkg::REG_FALLOFF:      falloff      <= pwdata[cdm_pkg::FALLOFF_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back raw values
  always_comb begin
    unique case (idx)
      cdm_pkg::REG_TARGET_RED:   prdata = {16'd0, target_red};
      cdm_pkg::REG_TARGET_GREEN: prdata = {16'd0, target_green};
      cdm_pkg::REG_TARGET_BLUE:  prdata = {16'd0, target_blue};
      cdm_pkg::REG_FALLOFF:      prdata = {17'd0, falloff};
      default:                   prdata = '0;
    endcase
  end

  // Clamp falloff and scale by 65535
  always_comb begin
    if (falloff < cdm_pkg::FALLOFF_MIN) begin
      falloff_clamped = cdm_pkg::FALLOFF_MIN;
    end else if (falloff > cdm_pkg::FALLOFF_MAX) begin
      falloff_clamped = cdm_pkg::FALLOFF_MAX;
    end else begin
      falloff_clamped = falloff;
    end
    divisor_next = {falloff_clamped, 16'd0} - {16'd0, falloff_clamped};
  end

  always_ff @(posedge clk) begin
    divisor <= divisor_next;
  end

  assign cfg.divisor      = divisor;
  assign cfg.target_red   = target_red;
  assign cfg.target_green = target_green;
  assign cfg.target_blue  = target_blue;

endmodule

// ----- rtl/core/cdm_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// cdm_sqrt_cell: one digit of the integer square root
// Brings down two radicand bits, tries the next root bit, hands on the word.
// ----------------------------------------------------------------------------
module cdm_sqrt_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                valid_in,
  input  cdm_pkg::sqrt_word_t word_in,
  output logic                valid_out,
  output cdm_pkg::sqrt_word_t word_out
);

  logic [cdm_pkg::SQ_REM_W+1:0] acc;
  logic [cdm_pkg::SQ_REM_W+1:0] trial;
  logic [cdm_pkg::SQ_REM_W+1:0] diff;
  logic                         ge;
  cdm_pkg::sqrt_word_t          word_next;

  // Try root bit one
  always_comb begin
    acc   = {word_in.rem, word_in.x[cdm_pkg::SQ_IN_W-1 -: 2]};
    trial = {2'b00, word_in.root, 2'b01};
    ge    = acc >= trial;
    diff  = acc - trial;
    word_next.x    = {word_in.x[cdm_pkg::SQ_IN_W-3:0], 2'b00};
    word_next.rem  = ge ? diff[cdm_pkg::SQ_REM_W-1:0] : acc[cdm_pkg::SQ_REM_W-1:0];
    word_next.root = {word_in.root[cdm_pkg::SQ_ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      word_out <= word_next;
    end
  end

endmodule

// ----- rtl/core/cdm_div_cell.sv -----
// ----------------------------------------------------------------------------
// cdm_div_cell: one quotient bit of the restoring divider
// Doubles the partial remainder, subtracts the divisor when it fits.
// ----------------------------------------------------------------------------
module cdm_div_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic [cdm_pkg::DIVISOR_W-1:0]  divisor,
  input  logic                           valid_in,
  input  cdm_pkg::div_word_t             word_in,
  output logic                           valid_out,
  output cdm_pkg::div_word_t             word_out
);

  logic [cdm_pkg::DIV_REM_W-1:0] shifted;
  logic [cdm_pkg::DIV_REM_W-1:0] dz;
  logic                          ge;
  cdm_pkg::div_word_t            word_next;

  // Subtract when the divisor fits
  always_comb begin
    shifted = {word_in.rem[cdm_pkg::DIV_REM_W-2:0], 1'b0};
    dz      = {1'b0, divisor};
    ge      = shifted >= dz;
    word_next.sat = word_in.sat;
    word_next.rem = ge ? (shifted - dz) : shifted;
    word_next.quo = {word_in.quo[cdm_pkg::DIV_Q_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      word_out <= word_next;
    end
  end

endmodule

// ----- rtl/core/cdm_smooth.sv -----
// ----------------------------------------------------------------------------
// cdm_smooth: smoothstep and mask rescale
// Four stages: clamp and square, times (3 - 2v), round, invert and rescale.
// ----------------------------------------------------------------------------
module cdm_smooth (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     valid_in,
  input  cdm_pkg::div_word_t       word_in,
  output logic                     valid_out,
  output logic [cdm_pkg::CH_W-1:0] mask_value
);

  logic [3:0]                         valid_pipe;
  logic [cdm_pkg::DIV_Q_W-1:0]        v;
  logic [2*cdm_pkg::DIV_Q_W-1:0]      vv_full;
  logic [2*cdm_pkg::DIV_Q_W-2:0]      vv;
  logic [17:0]                        t;
  logic [cdm_pkg::PROD_W-1:0]         prod;
  logic [cdm_pkg::PROD_W-1:0]         rnd;
  logic [cdm_pkg::PROD_W-33:0]        sm_raw;
  logic [cdm_pkg::DIV_Q_W-1:0]        sm;
  logic [cdm_pkg::DIV_Q_W-1:0]        inv;
  logic [32:0]                        scaled;

  // Clamp ratio, square it, form 3 - 2v
  always_comb begin
    if (word_in.sat || (word_in.quo > cdm_pkg::ONE_Q16)) begin
      v = cdm_pkg::ONE_Q16;
    end else begin
      v = word_in.quo;
    end
    vv_full = {17'd0, v} * {17'd0, v};
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vv <= vv_full[2*cdm_pkg::DIV_Q_W-2:0];
      t  <= cdm_pkg::THREE_Q16 - {v, 1'b0};
    end
  end

  // Full cubic product
  always_ff @(posedge clk) begin
    if (advance) begin
      prod <= {18'd0, vv} * {33'd0, t};
    end
  end

  // Round half up to Q16 and clamp
  always_comb begin
    rnd    = prod + cdm_pkg::ROUND_HALF;
    sm_raw = rnd[cdm_pkg::PROD_W-1:32];
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (sm_raw > {2'b00, cdm_pkg::ONE_Q16}) begin
        sm <= cdm_pkg::ONE_Q16;
      end else begin
        sm <= sm_raw[cdm_pkg::DIV_Q_W-1:0];
      end
    end
  end

  // Invert and rescale to 65535 full scale
  always_comb begin
    inv    = cdm_pkg::ONE_Q16 - sm;
    scaled = {inv, 16'd0} - {16'd0, inv} + 33'd32768;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mask_value <= scaled[31:16];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_pipe <= '0;
    end else if (advance) begin
      valid_pipe <= {valid_pipe[2:0], valid_in};
    end
  end

  assign valid_out = valid_pipe[3];

endmodule

// ----- rtl/core/color_distance_mask_unit.sv -----
// ----------------------------------------------------------------------------
// color_distance_mask_unit: per-pixel color key mask
// Euclidean distance to a target color over a falloff radius, smoothstep,
// inverted to a Q0.16 mask. Square root and divide run as cell chains.
//
//   channel  dir  handshake     payload
//   pixel    in   valid/ready   pixel_red, pixel_green, pixel_blue (16b each)
//   mask     out  valid/ready   mask_value (16b)
//   apb      in   psel/penable  4 registers at byte 0, 4, 8, 12
//
// One pixel is taken every cycle while no skid word is held.
// Each pixel passes the 25 square root cells and then the 17 divider cells.
// A skid word behind the output register lets the chain run one word past a
// stalled output; ready drops only while that skid word is held.
// Synchronous reset clears valid bits and loads register reset values.
// ----------------------------------------------------------------------------
module color_distance_mask_unit (
  input  logic                       clk,
  input  logic                       rst,
  cdm_pixel_if.sink                  pixel,
  cdm_mask_if.source                 mask,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cdm_pkg::ADDR_W-1:0] paddr,
  input  logic [cdm_pkg::DATA_W-1:0] pwdata,
  output logic [cdm_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  cdm_pkg::cfg_t cfg;

  logic                          advance;
  logic [2:0]                    front_valid;
  logic [cdm_pkg::CH_W-1:0]      diff_red;
  logic [cdm_pkg::CH_W-1:0]      diff_green;
  logic [cdm_pkg::CH_W-1:0]      diff_blue;
  logic [cdm_pkg::SQ_W-1:0]      sq_red;
  logic [cdm_pkg::SQ_W-1:0]      sq_green;
  logic [cdm_pkg::SQ_W-1:0]      sq_blue;
  logic [cdm_pkg::SUM_W-1:0]     sum;

  logic [cdm_pkg::SQ_ROOT_W:0]   sq_valid;
  cdm_pkg::sqrt_word_t           sq_word [0:cdm_pkg::SQ_ROOT_W];

  logic [cdm_pkg::DIV_REM_W-1:0] scaled_root;
  logic                          div_setup_valid;
  cdm_pkg::div_word_t            div_setup_word;
  logic [cdm_pkg::DIV_Q_W:0]     div_valid;
  cdm_pkg::div_word_t            div_word [0:cdm_pkg::DIV_Q_W];

  logic                          last_valid;
  logic [cdm_pkg::CH_W-1:0]      last_mask;
  logic                          out_valid;
  logic [cdm_pkg::CH_W-1:0]      out_mask;
  logic                          skid_valid;
  logic [cdm_pkg::CH_W-1:0]      skid_mask;

  // Configuration registers
  cdm_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Chain moves whenever the skid word is empty
  assign advance     = !skid_valid;
  assign pixel.ready = advance;

  // Absolute channel differences, squares, sum
  always_ff @(posedge clk) begin
    if (advance) begin
      diff_red   <= (pixel.pixel_red >= cfg.target_red) ?
                    (pixel.pixel_red - cfg.target_red) : (cfg.target_red - pixel.pixel_red);
      diff_green <= (pixel.pixel_green >= cfg.target_green) ?
                    (pixel.pixel_green - cfg.target_green) :
                    (cfg.target_green - pixel.pixel_green);
      diff_blue  <= (pixel.pixel_blue >= cfg.target_blue) ?
                    (pixel.pixel_blue - cfg.target_blue) : (cfg.target_blue - pixel.pixel_blue);
      sq_red     <= {16'd0, diff_red} * {16'd0, diff_red};
      sq_green   <= {16'd0, diff_green} * {16'd0, diff_green};
      sq_blue    <= {16'd0, diff_blue} * {16'd0, diff_blue};
      sum        <= {2'b00, sq_red} + {2'b00, sq_green} + {2'b00, sq_blue};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= '0;
    end else if (advance) begin
      front_valid <= {front_valid[1:0], pixel.valid};
    end
  end

  // Square root of sum << 16, one root bit per cell
  assign sq_valid[0]     = front_valid[2];
  assign sq_word[0].x    = {sum, 16'd0};
  assign sq_word[0].rem  = '0;
  assign sq_word[0].root = '0;

  for (genvar k = 0; k < cdm_pkg::SQ_ROOT_W; k++) begin : g_sqrt
    cdm_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .valid_in  (sq_valid[k]),
      .word_in   (sq_word[k]),
      .valid_out (sq_valid[k+1]),
      .word_out  (sq_word[k+1])
    );
  end

  // Divider setup: saturate when root * 32 reaches the divisor
  assign scaled_root = {2'b00, sq_word[cdm_pkg::SQ_ROOT_W].root, 5'd0};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_setup_valid <= 1'b0;
    end else if (advance) begin
      div_setup_valid <= sq_valid[cdm_pkg::SQ_ROOT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      div_setup_word.sat <= scaled_root >= {1'b0, cfg.divisor};
      div_setup_word.rem <= scaled_root;
      div_setup_word.quo <= '0;
    end
  end

  assign div_valid[0] = div_setup_valid;
  assign div_word[0]  = div_setup_word;

  // Ratio, one quotient bit per cell
  for (genvar k = 0; k < cdm_pkg::DIV_Q_W; k++) begin : g_div
    cdm_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .divisor   (cfg.divisor),
      .valid_in  (div_valid[k]),
      .word_in   (div_word[k]),
      .valid_out (div_valid[k+1]),
      .word_out  (div_word[k+1])
    );
  end

  // Smoothstep and mask
  cdm_smooth u_smooth (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .valid_in   (div_valid[cdm_pkg::DIV_Q_W]),
    .word_in    (div_word[cdm_pkg::DIV_Q_W]),
    .valid_out  (last_valid),
    .mask_value (last_mask)
  );

  // Output register with one skid word
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !mask.ready) begin
      if (advance && last_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= last_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !mask.ready) begin
      if (advance && last_valid) begin
        skid_mask <= last_mask;
      end
    end else if (skid_valid) begin
      out_mask <= skid_mask;
    end else begin
      out_mask <= last_mask;
    end
  end

  assign mask.valid      = out_valid;
  assign mask.mask_value = out_mask;

  // Checks
  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid word held without an output word");

  a_skid_drain: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && mask.ready) |=> (out_valid && !skid_valid && (out_mask == $past(skid_mask))))
    else $error("skid word not moved to output");

  a_divisor_range: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> ((cfg.divisor >= cdm_pkg::DIVISOR_MIN) &&
                     (cfg.divisor <= cdm_pkg::DIVISOR_MAX)))
    else $error("divisor outside clamped falloff range");

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench of the color distance mask unit
// Streams pixels through the unit under a range of target colors and falloff
// radii. It predicts each mask word in fixed point and compares it, in order,
// with the mask channel output. Both channels idle at random in most phases.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cdm_pkg::*;

  localparam int unsigned TIMEOUT_CYCLES = 400_000;
  localparam int unsigned DRAIN_CYCLES   = 60;
  localparam int unsigned PHASE_ITEMS    = 180;
  localparam int unsigned PHASE_COUNT    = 6;

  // Mask predictor and in-order store of expected mask words
  class mask_checker;
    bit [CH_W-1:0]      tgt_red;
    bit [CH_W-1:0]      tgt_green;
    bit [CH_W-1:0]      tgt_blue;
    bit [FALLOFF_W-1:0] falloff;
    bit [CH_W-1:0]      expected_masks[$];
    int unsigned        mismatches;

    function new();
      tgt_red    = TARGET_RESET;
      tgt_green  = TARGET_RESET;
      tgt_blue   = TARGET_RESET;
      falloff    = FALLOFF_RESET;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [DATA_W-1:0] data);
      case (idx)
        REG_TARGET_RED:   tgt_red   = data[CH_W-1:0];
        REG_TARGET_GREEN: tgt_green = data[CH_W-1:0];
        REG_TARGET_BLUE:  tgt_blue  = data[CH_W-1:0];
        REG_FALLOFF:      falloff   = data[FALLOFF_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_falloff();
      if (falloff < FALLOFF_MIN) return FALLOFF_MIN;
      if (falloff > FALLOFF_MAX) return FALLOFF_MAX;
      return falloff;
    endfunction

    // Root found one bit at a time from the top; input stays below 2^50
    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = SQ_ROOT_W - 1; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= x) root = trial;
      end
      return root;
    endfunction

    function longint unsigned abs_diff(bit [CH_W-1:0] a, bit [CH_W-1:0] b);
      return (a >= b) ? longint'(a - b) : longint'(b - a);
    endfunction

    function bit [CH_W-1:0] predict_mask(bit [CH_W-1:0] r, bit [CH_W-1:0] g,
                                         bit [CH_W-1:0] b);
      longint unsigned f;
      longint unsigned sum_sq;
      longint unsigned radius;
      longint unsigned ratio;
      longint unsigned tail;
      longint unsigned smooth;
      f = eff_falloff();
      sum_sq = abs_diff(r, tgt_red) ** 2 + abs_diff(g, tgt_green) ** 2
             + abs_diff(b, tgt_blue) ** 2;
      // distance in units of 1/(65535*256)
      radius = int_sqrt(sum_sq << 16);
      // ratio to the falloff in Q16, saturated at 1.0
      ratio = (radius << 22) / (64'd65535 * f);
      if (ratio > 64'd65536) ratio = 64'd65536;
      // smoothstep v*v*(3-2v), rounded half up
      tail = 64'd196608 - 2 * ratio;
      smooth = (ratio * ratio * tail + 64'h8000_0000) >> 32;
      if (smooth > 64'd65536) smooth = 64'd65536;
      // invert and rescale to 65535 = 1.0
      return CH_W'(((64'd65536 - smooth) * 64'd65535 + 64'd32768) >> 16);
    endfunction

    function void note_pixel(bit [CH_W-1:0] r, bit [CH_W-1:0] g, bit [CH_W-1:0] b);
      expected_masks.push_back(predict_mask(r, g, b));
    endfunction

    function void check_mask(bit [CH_W-1:0] actual);
      bit [CH_W-1:0] want;
      if (expected_masks.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: mask word %0d arrived with none expected", $realtime, actual);
        mismatches++;
        return;
      end
      want = expected_masks.pop_front();
      if (actual !== want) begin
        if (mismatches < 10)
          $display("%0t: mask_value expected %0d, got %0d", $realtime, want, actual);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_masks.size();
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  int unsigned         src_idle_pct;
  int unsigned         snk_idle_pct;

  mask_checker sb = new();

  cdm_pixel_if pixel_ch();
  cdm_mask_if  mask_ch();

  color_distance_mask_unit dut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pixel_ch),
    .mask    (mask_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Run limit
  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  // Stall the mask channel at random
  always @(negedge clk) begin
    mask_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Note accepted pixels first, then check accepted mask words
  always @(posedge clk) begin
    if (!rst) begin
      if (pixel_ch.valid && pixel_ch.ready)
        sb.note_pixel(pixel_ch.pixel_red, pixel_ch.pixel_green, pixel_ch.pixel_blue);
      if (mask_ch.valid && mask_ch.ready)
        sb.check_mask(mask_ch.mask_value);
    end
  end

  // Offer one pixel word and hold it until taken; returns at a falling edge
  task automatic send_pixel(bit [CH_W-1:0] r, bit [CH_W-1:0] g, bit [CH_W-1:0] b);
    while ($urandom_range(99) < src_idle_pct) begin
      pixel_ch.valid <= 1'b0;
      @(negedge clk);
    end
    pixel_ch.valid       <= 1'b1;
    pixel_ch.pixel_red   <= r;
    pixel_ch.pixel_green <= g;
    pixel_ch.pixel_blue  <= b;
    @(posedge clk);
    while (!pixel_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected mask word has come back
  task automatic drain_masks();
    pixel_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
  endtask

  // One register write: setup cycle, then access cycle; psel stays up
  task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
  endtask

  // Load all four registers; upper data bits carry junk
  task automatic load_config(bit [CH_W-1:0] r, bit [CH_W-1:0] g, bit [CH_W-1:0] b,
                             bit [CH_W-1:0] f);
    logic [DATA_W-1:0] junk;
    junk = $urandom;
    reg_write(REG_TARGET_RED,   {junk[31:16], r});
    reg_write(REG_TARGET_GREEN, {junk[15:0], g});
    reg_write(REG_TARGET_BLUE,  {junk[23:8], b});
    reg_write(REG_FALLOFF,      {junk[31:16], f});
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  function automatic bit [CH_W-1:0] near_value(bit [CH_W-1:0] center, int unsigned spread);
    int v;
    v = int'(center) + int'($urandom_range(2 * spread)) - int'(spread);
    if (v < 0) v = 0;
    else if (v > 65535) v = 65535;
    return CH_W'(v);
  endfunction

  // Mostly pixels near the target color, the rest far or at the rails
  task automatic send_random_pixel();
    bit [CH_W-1:0] ch[3];
    bit [CH_W-1:0] tg[3];
    int unsigned   kind;
    int unsigned   spread;
    tg     = '{sb.tgt_red, sb.tgt_green, sb.tgt_blue};
    spread = 4 * sb.eff_falloff() + 8;
    kind   = $urandom_range(99);
    for (int i = 0; i < 3; i++) begin
      if (kind < 60) begin
        ch[i] = near_value(tg[i], spread);
      end else if (kind < 80) begin
        ch[i] = CH_W'($urandom);
      end else if (kind < 90) begin
        ch[i] = (i == int'(kind % 3)) ? CH_W'($urandom) : near_value(tg[i], spread);
      end else begin
        case ($urandom_range(2))
          0: ch[i] = '0;
          1: ch[i] = '1;
          default: ch[i] = tg[i];
        endcase
      end
    end
    send_pixel(ch[0], ch[1], ch[2]);
  endtask

  initial begin
    bit [CH_W-1:0] fr;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    pixel_ch.valid <= 1'b0;
    pixel_ch.pixel_red   <= '0;
    pixel_ch.pixel_green <= '0;
    pixel_ch.pixel_blue  <= '0;
    rst            <= 1'b1;
    src_idle_pct    = 23;
    snk_idle_pct   <= 69;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset colors: exact match, far corner, small steps along each axis
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'hFFFE, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF - 16'd3000, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF - 16'd6000, 16'hFFFF);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF - 16'd9000);
    send_pixel(16'hFFFF - 16'd9832, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hFFFF - 16'd5000, 16'hFFFF - 16'd5000, 16'hFFFF - 16'd5000);

    // Falloff below the floor is used as the floor
    drain_masks();
    load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'h0001, 16'h0000, 16'h0000);
    send_pixel(16'h0000, 16'h0000, 16'd40);
    send_pixel(16'h0000, 16'd68, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);

    // Falloff above the ceiling is used as the ceiling; full diagonal still inside
    drain_masks();
    load_config(16'h8000, 16'h8000, 16'h8000, 16'h7FFF);
    send_pixel(16'h8000, 16'h8000, 16'h8000);
    send_pixel(16'h0000, 16'h0000, 16'h0000);
    send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(16'hAAAA, 16'h5555, 16'hAAAA);
    send_pixel(16'h5555, 16'hAAAA, 16'h5555);

    // Random phases, each under its own colors and idle pattern
    for (int p = 0; p < PHASE_COUNT; p++) begin
      drain_masks();
      src_idle_pct  = (p < 2) ? 23 : (p < 4) ? 69 : 0;
      snk_idle_pct <= (p < 2) ? 69 : (p < 4) ? 23 : 0;
      case (p)
        0: fr = CH_W'($urandom_range(32767));
        1: fr = CH_W'(FALLOFF_MIN);
        2: fr = CH_W'(FALLOFF_MAX);
        3: fr = CH_W'($urandom_range(100));
        4: fr = 16'h7FFF;
        default: fr = CH_W'($urandom_range(FALLOFF_MAX, FALLOFF_MIN));
      endcase
      case (p)
        1: load_config(16'h0000, 16'h0000, 16'h0000, fr);
        2: load_config(16'hFFFF, 16'h0000, 16'hFFFF, fr);
        default: load_config(CH_W'($urandom), CH_W'($urandom), CH_W'($urandom), fr);
      endcase
      repeat (PHASE_ITEMS) send_random_pixel();
    end

    // Let the pipe empty, then watch for strays
    pixel_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
